>>> src/mhu_pkg.sv
package mhu_pkg;

  // Frame geometry and ring depth
  localparam int unsigned FrameWidth  = 640;
  localparam int unsigned FrameHeight = 480;
  localparam int unsigned Frames      = 4;
  localparam int unsigned Pixels      = FrameWidth * FrameHeight;

  localparam int unsigned PosW  = (Pixels > 1) ? $clog2(Pixels) : 1;
  localparam int unsigned HwmW  = $clog2(Pixels + 1);
  localparam int unsigned SlotW = $clog2(Frames);

  // Field widths
  localparam int unsigned ColorW = 8;
  localparam int unsigned GrayW  = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned DurW   = 20;
  localparam int unsigned GainW  = 24;
  localparam int unsigned MaskW  = 8;

  // Gray weights, 14-bit fixed point
  localparam int unsigned GraySumW  = 22;
  localparam int unsigned GrayShift = 14;
  localparam int unsigned GrayWr    = 4899;
  localparam int unsigned GrayWg    = 9617;
  localparam int unsigned GrayWb    = 1868;
  localparam int unsigned GrayRound = 8192;

  // Mask scaling: age is signed 34 bits, clamped to 2^24 before the multiply
  localparam int unsigned AgeW       = TimeW + 2;
  localparam int unsigned MaskAgeW   = 25;
  localparam int unsigned ProdW      = MaskAgeW + GainW;
  localparam int unsigned MaskShift  = 16;
  localparam int unsigned MaskRound  = 32768;

  // Configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = AddrW - 2;

  localparam logic [RegIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [RegIdxW-1:0] RegDuration  = 2'd1;
  localparam logic [RegIdxW-1:0] RegGain      = 2'd2;

  localparam logic [ThrW-1:0]  ThresholdRst = 8'd30;
  localparam logic [DurW-1:0]  DurationRst  = 20'd1000;
  localparam logic [GainW-1:0] GainRst      = 24'd16712;

  typedef struct packed {
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic [TimeW-1:0]  time_now;
    logic              last_in_frame;
  } mhu_in_t;

  typedef struct packed {
    logic              motion;
    logic [TimeW-1:0]  history_time;
    logic [MaskW-1:0]  mask_level;
  } mhu_out_t;

  typedef struct packed {
    logic [ThrW-1:0]  threshold;
    logic [DurW-1:0]  duration;
    logic [GainW-1:0] gain;
  } mhu_cfg_t;

  function automatic logic [GrayW-1:0] to_gray(input logic [ColorW-1:0] b,
                                               input logic [ColorW-1:0] g,
                                               input logic [ColorW-1:0] r);
    logic [GraySumW-1:0] sum;
    sum = GraySumW'(GrayWr) * GraySumW'(r) + GraySumW'(GrayWg) * GraySumW'(g)
        + GraySumW'(GrayWb) * GraySumW'(b) + GraySumW'(GrayRound);
    return sum[GrayShift +: GrayW];
  endfunction

endpackage

>>> src/mhu_cfg_regs.sv
module mhu_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mhu_pkg::AddrW-1:0]    paddr,
  input  logic [mhu_pkg::DataW-1:0]    pwdata,
  output logic [mhu_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output mhu_pkg::mhu_cfg_t            cfg_o
);

  mhu_pkg::mhu_cfg_t cfg_q, cfg_d;
  logic [mhu_pkg::RegIdxW-1:0] idx;
  logic wr_en;

  assign idx    = paddr[mhu_pkg::AddrW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        mhu_pkg::RegThreshold: cfg_d.threshold = pwdata[mhu_pkg::ThrW-1:0];
        mhu_pkg::RegDuration:  cfg_d.duration  = pwdata[mhu_pkg::DurW-1:0];
        mhu_pkg::RegGain:      cfg_d.gain      = pwdata[mhu_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mhu_pkg::RegThreshold: prdata = mhu_pkg::DataW'(cfg_q.threshold);
      mhu_pkg::RegDuration:  prdata = mhu_pkg::DataW'(cfg_q.duration);
      mhu_pkg::RegGain:      prdata = mhu_pkg::DataW'(cfg_q.gain);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= mhu_pkg::ThresholdRst;
      cfg_q.duration  <= mhu_pkg::DurationRst;
      cfg_q.gain      <= mhu_pkg::GainRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> src/motion_history_update.sv
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o     in_data_i   (mhu_in_t)
// out       output     out_valid_o / out_ready_i   out_data_o  (mhu_out_t)
// cfg       input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One pixel transfer per cycle sustained while out_ready_i keeps up; four
// register stages (read, update/write-back, age, multiply) lie between an
// input transfer and its result.
// Gray frames sit in one RAM row per pixel (one byte lane per ring slot), the
// history in a second RAM; both have one read port and one write port.
// After reset no clearing pass runs: per-slot and history watermarks mark which
// rows were written since reset, and rows at or above them read as zero.
// A stall on out_ready_i backs up stage by stage; empty stages still fill.
module motion_history_update (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mhu_pkg::mhu_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mhu_pkg::mhu_out_t         out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mhu_pkg::AddrW-1:0] paddr,
  input  logic [mhu_pkg::DataW-1:0] pwdata,
  output logic [mhu_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned RowW    = mhu_pkg::Frames * mhu_pkg::GrayW;
  localparam int unsigned ScaledW = mhu_pkg::ProdW - mhu_pkg::MaskShift;

  mhu_pkg::mhu_cfg_t cfg;

  mhu_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Pixel position and ring slot
  // ---------------------------------------------------------------------------
  logic [mhu_pkg::PosW-1:0]  pos_q, pos_d;
  logic [mhu_pkg::SlotW-1:0] slot_q, slot_d;
  logic [mhu_pkg::SlotW-1:0] oldest;
  logic                      accept;

  assign oldest = (slot_q == mhu_pkg::SlotW'(mhu_pkg::Frames - 1))
                ? '0 : slot_q + mhu_pkg::SlotW'(1);

  always_comb begin
    pos_d  = pos_q;
    slot_d = slot_q;
    if (accept) begin
      if (in_data_i.last_in_frame) begin
        pos_d  = '0;
        slot_d = oldest;
      end else if (pos_q == mhu_pkg::PosW'(mhu_pkg::Pixels - 1)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + mhu_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      slot_q <= '0;
    end else begin
      pos_q  <= pos_d;
      slot_q <= slot_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic ld1, ld2, ld3, ld4;
  logic wb;   // s1 item writes back this edge

  assign ld4        = !s4_v_q || out_ready_i;
  assign ld3        = !s3_v_q || ld4;
  assign ld2        = !s2_v_q || ld3;
  assign ld1        = !s1_v_q || ld2;
  assign in_ready_o = ld1;
  assign accept     = in_valid_i && ld1;
  assign wb         = s1_v_q && ld2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (ld1) s1_v_q <= in_valid_i;
      if (ld2) s2_v_q <= s1_v_q;
      if (ld3) s3_v_q <= s2_v_q;
      if (ld4) s4_v_q <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers: gray value, addresses, forwarding from the write-back
  // that lands on the same edge as this item's RAM read
  // ---------------------------------------------------------------------------
  logic [mhu_pkg::GrayW-1:0] s1_gray_q;
  logic [mhu_pkg::PosW-1:0]  s1_pos_q;
  logic [mhu_pkg::SlotW-1:0] s1_slot_q, s1_oldest_q;
  logic [mhu_pkg::TimeW-1:0] s1_now_q;
  logic                      fwd_frame_hit_q, fwd_hist_hit_q;
  logic [mhu_pkg::GrayW-1:0] fwd_gray_q;
  logic [mhu_pkg::TimeW-1:0] fwd_hist_q;
  logic [mhu_pkg::TimeW-1:0] s1_hist_new;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_gray_q       <= mhu_pkg::to_gray(in_data_i.blue, in_data_i.green, in_data_i.red);
      s1_pos_q        <= pos_q;
      s1_slot_q       <= slot_q;
      s1_oldest_q     <= oldest;
      s1_now_q        <= in_data_i.time_now;
      fwd_frame_hit_q <= wb && (s1_pos_q == pos_q) && (s1_slot_q == oldest);
      fwd_gray_q      <= s1_gray_q;
      fwd_hist_hit_q  <= wb && (s1_pos_q == pos_q);
      fwd_hist_q      <= s1_hist_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: frame ring (byte lane per slot) and motion history
  // ---------------------------------------------------------------------------
  logic [RowW-1:0]           frame_mem [mhu_pkg::Pixels];
  logic [mhu_pkg::TimeW-1:0] hist_mem  [mhu_pkg::Pixels];
  logic [RowW-1:0]           frame_rd_q;
  logic [mhu_pkg::TimeW-1:0] hist_rd_q;

  always_ff @(posedge clk_i) begin
    if (wb) frame_mem[s1_pos_q][s1_slot_q*mhu_pkg::GrayW +: mhu_pkg::GrayW] <= s1_gray_q;
    if (accept) frame_rd_q <= frame_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (wb) hist_mem[s1_pos_q] <= s1_hist_new;
    if (accept) hist_rd_q <= hist_mem[pos_q];
  end

  // Watermarks: rows below them have been written since reset.
  // Positions are always visited as a prefix from zero, so max+1 is enough.
  logic [mhu_pkg::HwmW-1:0] frame_hwm_q [mhu_pkg::Frames];
  logic [mhu_pkg::HwmW-1:0] hist_hwm_q;
  logic [mhu_pkg::HwmW-1:0] s1_pos_ext, s1_pos_next;

  assign s1_pos_ext  = mhu_pkg::HwmW'(s1_pos_q);
  assign s1_pos_next = s1_pos_ext + mhu_pkg::HwmW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mhu_pkg::Frames; i++) frame_hwm_q[i] <= '0;
      hist_hwm_q <= '0;
    end else if (wb) begin
      if (s1_pos_next > frame_hwm_q[s1_slot_q]) frame_hwm_q[s1_slot_q] <= s1_pos_next;
      if (s1_pos_next > hist_hwm_q) hist_hwm_q <= s1_pos_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 logic: difference, threshold, history update
  // ---------------------------------------------------------------------------
  logic [mhu_pkg::GrayW-1:0] prev_gray, diff;
  logic [mhu_pkg::TimeW-1:0] hist_old, dur_ext, hist_limit;
  logic                      s1_moved, expired;

  assign dur_ext = mhu_pkg::TimeW'(cfg.duration);

  always_comb begin
    if (fwd_frame_hit_q) begin
      prev_gray = fwd_gray_q;
    end else if (s1_pos_ext < frame_hwm_q[s1_oldest_q]) begin
      prev_gray = frame_rd_q[s1_oldest_q*mhu_pkg::GrayW +: mhu_pkg::GrayW];
    end else begin
      prev_gray = '0;
    end

    if (fwd_hist_hit_q) begin
      hist_old = fwd_hist_q;
    end else if (s1_pos_ext < hist_hwm_q) begin
      hist_old = hist_rd_q;
    end else begin
      hist_old = '0;
    end

    diff       = (s1_gray_q > prev_gray) ? s1_gray_q - prev_gray : prev_gray - s1_gray_q;
    s1_moved   = diff > cfg.threshold;
    hist_limit = s1_now_q - dur_ext;
    expired    = (s1_now_q >= dur_ext) && (hist_old < hist_limit);

    if (s1_moved)     s1_hist_new = s1_now_q;
    else if (expired) s1_hist_new = '0;
    else              s1_hist_new = hist_old;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: history age, clamped to 2^24 (saturates the mask for any nonzero
  // gain, stays zero for zero gain)
  // ---------------------------------------------------------------------------
  logic                      s2_motion_q;
  logic [mhu_pkg::TimeW-1:0] s2_hist_q, s2_now_q;
  logic [mhu_pkg::AgeW-1:0]  age;
  logic [mhu_pkg::MaskAgeW-1:0] age_clamp;

  always_ff @(posedge clk_i) begin
    if (ld2 && s1_v_q) begin
      s2_motion_q <= s1_moved;
      s2_hist_q   <= s1_hist_new;
      s2_now_q    <= s1_now_q;
    end
  end

  always_comb begin
    age = mhu_pkg::AgeW'(s2_hist_q) - mhu_pkg::AgeW'(s2_now_q)
        + mhu_pkg::AgeW'(cfg.duration);
    if (age[mhu_pkg::AgeW-1] || (age == '0)) begin
      age_clamp = '0;
    end else if (|age[mhu_pkg::AgeW-2:mhu_pkg::MaskAgeW-1]) begin
      age_clamp = mhu_pkg::MaskAgeW'(1) << (mhu_pkg::MaskAgeW - 1);
    end else begin
      age_clamp = age[mhu_pkg::MaskAgeW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: age times gain
  // ---------------------------------------------------------------------------
  logic                         s3_motion_q;
  logic [mhu_pkg::TimeW-1:0]    s3_hist_q;
  logic [mhu_pkg::MaskAgeW-1:0] s3_age_q;

  always_ff @(posedge clk_i) begin
    if (ld3 && s2_v_q) begin
      s3_motion_q <= s2_motion_q;
      s3_hist_q   <= s2_hist_q;
      s3_age_q    <= age_clamp;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: output register; rounding and saturation of the product
  // ---------------------------------------------------------------------------
  logic                      s4_motion_q;
  logic [mhu_pkg::TimeW-1:0] s4_hist_q;
  logic [mhu_pkg::ProdW-1:0] s4_prod_q;
  logic [mhu_pkg::ProdW-1:0] rounded;
  logic [ScaledW-1:0]        scaled;

  always_ff @(posedge clk_i) begin
    if (ld4 && s3_v_q) begin
      s4_motion_q <= s3_motion_q;
      s4_hist_q   <= s3_hist_q;
      s4_prod_q   <= mhu_pkg::ProdW'(s3_age_q) * mhu_pkg::ProdW'(cfg.gain);
    end
  end

  assign rounded = s4_prod_q + mhu_pkg::ProdW'(mhu_pkg::MaskRound);
  assign scaled  = rounded[mhu_pkg::ProdW-1:mhu_pkg::MaskShift];

  assign out_valid_o             = s4_v_q;
  assign out_data_o.motion       = s4_motion_q;
  assign out_data_o.history_time = s4_hist_q;
  assign out_data_o.mask_level   = (|scaled[ScaledW-1:mhu_pkg::MaskW])
                                 ? '1 : scaled[mhu_pkg::MaskW-1:0];

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned LongHold   = 150;   // receiver hold-off, cycles
  localparam int unsigned TailWait   = 12;    // > pipeline depth of 4

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  mhu_pkg::mhu_in_t          in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  mhu_pkg::mhu_out_t         out_data_o;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [mhu_pkg::AddrW-1:0] paddr       = '0;
  logic [mhu_pkg::DataW-1:0] pwdata      = '0;
  logic [mhu_pkg::DataW-1:0] prdata;
  logic                      pready;

  motion_history_update u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted state: gray ring, history per pixel, raster position, ring slot,
  // and a copy of the three settings.
  // ---------------------------------------------------------------------------
  bit [mhu_pkg::GrayW-1:0] gray_ring [mhu_pkg::Frames][mhu_pkg::Pixels];
  bit [mhu_pkg::TimeW-1:0] hist_mem  [mhu_pkg::Pixels];
  int unsigned             pixel_pos = 0;
  int unsigned             ring_slot = 0;

  logic [mhu_pkg::ThrW-1:0]  cfg_threshold = mhu_pkg::ThresholdRst;
  logic [mhu_pkg::DurW-1:0]  cfg_duration  = mhu_pkg::DurationRst;
  logic [mhu_pkg::GainW-1:0] cfg_gain      = mhu_pkg::GainRst;

  mhu_pkg::mhu_in_t  pending_pixels   [$];
  mhu_pkg::mhu_out_t expected_updates [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  tx_calm        = 1'b0;
  bit  rx_calm        = 1'b1;

  // Update the predicted state with one pixel and return its result.
  function automatic mhu_pkg::mhu_out_t advance_history(mhu_pkg::mhu_in_t px);
    int unsigned               luma, pos, oldest;
    logic [mhu_pkg::GrayW-1:0] gray, prev, diff;
    logic [mhu_pkg::TimeW-1:0] hist;
    longint                    hist_l, now_l, age;
    longint unsigned           age_u, gain_u, scaled;
    mhu_pkg::mhu_out_t         res;
    if (pixel_pos >= mhu_pkg::Pixels) pixel_pos = 0;
    if (ring_slot >= mhu_pkg::Frames) ring_slot = 0;
    pos    = pixel_pos;
    oldest = (ring_slot + 1) % mhu_pkg::Frames;

    // 0.299/0.587/0.114 in 14-bit fixed point, rounded
    luma = (4899 * px.red + 9617 * px.green + 1868 * px.blue + 8192) >> 14;
    gray = luma[mhu_pkg::GrayW-1:0];
    gray_ring[ring_slot][pos] = gray;
    prev = gray_ring[oldest][pos];
    diff = (gray > prev) ? gray - prev : prev - gray;
    res.motion = (diff > cfg_threshold);

    // motion stamps the time; otherwise stale entries clear, but only once
    // time has reached the duration
    hist = hist_mem[pos];
    if (res.motion)
      hist = px.time_now;
    else if (px.time_now >= 32'(cfg_duration) && hist < px.time_now - 32'(cfg_duration))
      hist = '0;
    hist_mem[pos]    = hist;
    res.history_time = hist;

    // age may be zero or negative: mask is zero then
    hist_l = hist;
    now_l  = px.time_now;
    age    = hist_l - now_l + longint'(cfg_duration);
    if (age <= 0) begin
      res.mask_level = '0;
    end else begin
      age_u  = age;
      gain_u = cfg_gain;
      scaled = (age_u * gain_u + 64'd32768) >> 16;
      res.mask_level = (scaled > 255) ? 8'd255 : scaled[7:0];
    end

    if (px.last_in_frame) begin
      pixel_pos = 0;
      ring_slot = oldest;
    end else begin
      pixel_pos = (pos + 1 >= mhu_pkg::Pixels) ? 0 : pos + 1;
    end
    return res;
  endfunction

  // Per-item wait, 0..15; "calm" stretches give back-to-back traffic.
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 40) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued pixels; payload held until the transfer.
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_updates.push_back(advance_history(in_data_i));
        gap_left = draw_gap(tx_calm);
      end else if (!in_valid_i && gap_left > 0) begin
        gap_left = gap_left - 1;
      end

      if (in_valid_i && !in_ready_o) begin
        // still waiting for the transfer
      end else if (gap_left == 0 && pending_pixels.size() != 0) begin
        in_data_i  <= pending_pixels.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls per result, plus two long hold-offs so the pipeline
  // backs up into in_ready_o.
  // ---------------------------------------------------------------------------
  int stall_left   = 0;
  int results_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    mhu_pkg::mhu_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_updates.size() == 0) begin
          $error("result with nothing expected: motion %0d history_time %0d mask_level %0d",
                 out_data_o.motion, out_data_o.history_time, out_data_o.mask_level);
          mismatch_count++;
        end else begin
          want = expected_updates.pop_front();
          if (out_data_o.motion !== want.motion) begin
            $error("motion: expected %0d, got %0d", want.motion, out_data_o.motion);
            mismatch_count++;
          end
          if (out_data_o.history_time !== want.history_time) begin
            $error("history_time: expected %0d, got %0d",
                   want.history_time, out_data_o.history_time);
            mismatch_count++;
          end
          if (out_data_o.mask_level !== want.mask_level) begin
            $error("mask_level: expected %0d, got %0d",
                   want.mask_level, out_data_o.mask_level);
            mismatch_count++;
          end
        end
        results_seen++;
        if (results_seen == 300 || results_seen == 1200)
          stall_left = LongHold;
        else
          stall_left = draw_gap(rx_calm);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $error("timeout, %0d results outstanding", expected_updates.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid_i || expected_updates.size() != 0)
      @(posedge clk_i);
  endtask

  // APB write then read-back; upper pwdata bits carry junk the block must drop.
  task automatic write_setting(input logic [mhu_pkg::RegIdxW-1:0] idx,
                               input logic [mhu_pkg::DataW-1:0] value);
    logic [mhu_pkg::DataW-1:0] field_mask;
    logic [mhu_pkg::DataW-1:0] readback;
    case (idx)
      mhu_pkg::RegThreshold: field_mask = 32'h0000_00FF;
      mhu_pkg::RegDuration:  field_mask = 32'h000F_FFFF;
      default:               field_mask = 32'h00FF_FFFF;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value | ($urandom & ~field_mask);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);             // write lands here
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mhu_pkg::RegThreshold: cfg_threshold = value[mhu_pkg::ThrW-1:0];
      mhu_pkg::RegDuration:  cfg_duration  = value[mhu_pkg::DurW-1:0];
      default:               cfg_gain      = value[mhu_pkg::GainW-1:0];
    endcase

    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== (value & field_mask)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value & field_mask,
             readback);
      mismatch_count++;
    end
  endtask

  task automatic apply_settings(input int unsigned thr, input int unsigned dur,
                                input int unsigned gain);
    wait_idle();
    write_setting(mhu_pkg::RegThreshold, thr);
    write_setting(mhu_pkg::RegDuration, dur);
    write_setting(mhu_pkg::RegGain, gain);
  endtask

  task automatic queue_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                             input logic [31:0] stamp, input logic last);
    mhu_pkg::mhu_in_t px;
    px.blue          = b;
    px.green         = g;
    px.red           = r;
    px.time_now      = stamp;
    px.last_in_frame = last;
    pending_pixels.push_back(px);
  endtask

  // Short frames over a slowly changing scene, so pixels line up with the
  // frame three back and most compare as still. Frame times step around the
  // duration to hit both sides of the clearing rule. A few items are noise:
  // odd timestamps, stray or missing end-of-frame marks.
  task automatic queue_scene_frames(input int count);
    logic [23:0]      scene [64];
    logic [23:0]      c;
    logic [31:0]      stamp;
    int unsigned      dur, steady_len, frame_len, pushed, k;
    mhu_pkg::mhu_in_t px;
    dur = cfg_duration;
    for (k = 0; k < 64; k++) scene[k] = $urandom;
    steady_len = $urandom_range(1, 24);
    stamp  = $urandom;
    pushed = 0;
    while (pushed < count) begin
      frame_len = ($urandom_range(0, 3) != 0) ? steady_len : $urandom_range(1, 40);
      case ($urandom_range(0, 5))
        0:       stamp = stamp + $urandom_range(0, 3);
        1:       stamp = stamp + $urandom_range(0, dur);
        2:       stamp = stamp + dur + $urandom_range(0, 2) - 1;   // around the edge
        3:       stamp = stamp + dur * $urandom_range(1, 3);
        4:       stamp = $urandom_range(0, 2 * dur + 2);           // near zero
        default: stamp = $urandom;
      endcase
      for (k = 0; k < frame_len; k++) begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: c = scene[k];
          4, 5: c = scene[k] ^ {4'd0, 4'($urandom), 4'd0, 4'($urandom), 4'd0, 4'($urandom)};
          6: begin
            c = $urandom;
            scene[k] = c;
          end
          default: c = $urandom;
        endcase
        px.blue          = c[7:0];
        px.green         = c[15:8];
        px.red           = c[23:16];
        px.time_now      = ($urandom_range(0, 31) == 0) ? $urandom : stamp;
        px.last_in_frame = (k == frame_len - 1);
        if ($urandom_range(0, 63) == 0) px.last_in_frame = !px.last_in_frame;
        pending_pixels.push_back(px);
      end
      pushed += frame_len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned thr, dur, gain, p;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings (threshold 30, duration 1000), one-pixel
    // frames so every pixel hits position 0 back to back.
    queue_pixel(8'd0,   8'd0,   8'd0,   32'd0,    1'b1); // zero vs zero ring
    queue_pixel(8'd255, 8'd255, 8'd255, 32'd0,    1'b1); // motion at time 0
    queue_pixel(8'd255, 8'd0,   8'd0,   32'd500,  1'b1); // gray 29: just under; time < duration
    queue_pixel(8'd0,   8'd255, 8'd0,   32'd1000, 1'b1); // motion, stamp 1000
    queue_pixel(8'd0,   8'd0,   8'd255, 32'd1000, 1'b1);
    queue_pixel(8'd255, 8'd0,   8'd0,   32'd1500, 1'b1); // still: entry kept
    queue_pixel(8'd0,   8'd255, 8'd0,   32'd1500, 1'b1);
    queue_pixel(8'd0,   8'd0,   8'd255, 32'd2000, 1'b1); // age exactly zero
    queue_pixel(8'd255, 8'd0,   8'd0,   32'd2001, 1'b1); // one tick stale: cleared
    queue_pixel(8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1); // time at max
    queue_pixel(8'd0,   8'd0,   8'd255, 32'hFFFF_FFFF, 1'b1);
    queue_pixel(8'd0,   8'd0,   8'd100, 32'hFFFF_FFFF, 1'b1); // gray 30
    // multi-pixel frames, end marked only on the last pixel
    queue_pixel(8'd255, 8'd255, 8'd255, 32'h8000_0000, 1'b0);
    queue_pixel(8'd0,   8'd0,   8'd0,   32'h8000_0000, 1'b0);
    queue_pixel(8'd170, 8'd85,  8'd170, 32'h8000_0000, 1'b1);
    queue_pixel(8'd0,   8'd0,   8'd0,   32'h7FFF_FFFF, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 32'h7FFF_FFFF, 1'b0);
    queue_pixel(8'd85,  8'd170, 8'd85,  32'h7FFF_FFFF, 1'b1);

    // Random phases, each under its own settings.
    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin thr = 0;   dur = 1;         gain = 16711680; end   // extremes
        1: begin thr = 255; dur = 1048575;   gain = 0;        end
        2: begin thr = 30;  dur = 1000;      gain = 16712;    end
        3: begin thr = $urandom_range(0, 255); dur = 0; gain = $urandom_range(0, 16711680); end
        4: begin thr = $urandom_range(0, 255); dur = $urandom_range(1, 1048575);
                 gain = $urandom & 32'h00FF_FFFF; end
        default: begin
          thr  = $urandom_range(0, 60);
          dur  = $urandom_range(1, 5000);
          gain = (255 * 65536) / dur;
        end
      endcase
      apply_settings(thr, dur, gain);
      queue_scene_frames(240);
    end

    wait_idle();
    repeat (TailWait) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
